// ===== sv/tgu_pkg.sv =====
package tgu_pkg;

   localparam int WORD_TRITS    = 16;
   localparam int TRIT_W        = 2;
   localparam int WORD_W        = 32;
   localparam int OPERAND_TRITS = WORD_W / TRIT_W;
   localparam int OPCODE_W      = 4;
   localparam int COUNT_IN_W    = 5;
   localparam int COST_W        = 16;
   localparam int DELAY_W       = 7;
   localparam int CSR_INDEX_W   = 2;
   localparam int CNT_W         = $clog2(WORD_TRITS + 1);
   localparam int ACT_W         = (CNT_W < 2) ? 2 : CNT_W;
   localparam int ENERGY_W      = COST_W + ACT_W;
   localparam int LEVELS        = $clog2(WORD_TRITS);

   localparam logic [DELAY_W-1:0] DELAY_INV  = DELAY_W'(30);
   localparam logic [DELAY_W-1:0] DELAY_NAND = DELAY_W'(55);
   localparam logic [DELAY_W-1:0] DELAY_ADD  = DELAY_W'(85);

   localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'd0;
   localparam logic [TRIT_W-1:0] TRIT_ONE  = 2'd1;
   localparam logic [TRIT_W-1:0] TRIT_TWO  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_COST_NOT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_NAND     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_FULL_ADD = 2'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_NOT      = 4'd0,
      OP_NAND     = 4'd1,
      OP_NOR      = 4'd2,
      OP_AND      = 4'd3,
      OP_OR       = 4'd4,
      OP_MIN      = 4'd5,
      OP_MAX      = 4'd6,
      OP_HALF_ADD = 4'd7,
      OP_FULL_ADD = 4'd8,
      OP_WORD_ADD = 4'd9
   } opcode_type;

   typedef logic [TRIT_W-1:0] trit_type;

   // indexed by incoming carry 0..2
   typedef trit_type [2:0] trit_map_type;

   typedef struct packed {
      trit_map_type sum;
      trit_map_type carry;
   } lane_map_type;

   typedef struct packed {
      trit_type carry;
      trit_type sum;
   } digit_type;

   typedef struct packed {
      logic                word_add;
      trit_type            res;
      trit_type            carry;
      logic [ACT_W-1:0]    gates;
      logic [ACT_W-1:0]    transitions;
      logic [ENERGY_W-1:0] energy;
      logic                delay_set;
      logic [DELAY_W-1:0]  delay;
   } gate_info_type;

   function automatic trit_type trit_inv(trit_type a);
      trit_type r;
      if (a == TRIT_ZERO) r = TRIT_TWO;
      else if (a == TRIT_TWO) r = TRIT_ZERO;
      else r = TRIT_ONE;
      return r;
   endfunction

   function automatic trit_type trit_nand(trit_type a, trit_type b);
      trit_type r;
      if (a == TRIT_ZERO || b == TRIT_ZERO) r = TRIT_TWO;
      else if (a == TRIT_TWO && b == TRIT_TWO) r = TRIT_ZERO;
      else r = TRIT_ONE;
      return r;
   endfunction

   function automatic trit_type trit_max(trit_type a, trit_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic trit_type trit_min(trit_type a, trit_type b);
      return (a < b) ? a : b;
   endfunction

   // sum mod 3 and carry clamped to 2, for totals up to 9
   function automatic digit_type add_digits(logic [3:0] t);
      digit_type d;
      unique case (t)
         4'd0: d = '{carry: TRIT_ZERO, sum: TRIT_ZERO};
         4'd1: d = '{carry: TRIT_ZERO, sum: TRIT_ONE};
         4'd2: d = '{carry: TRIT_ZERO, sum: TRIT_TWO};
         4'd3: d = '{carry: TRIT_ONE,  sum: TRIT_ZERO};
         4'd4: d = '{carry: TRIT_ONE,  sum: TRIT_ONE};
         4'd5: d = '{carry: TRIT_ONE,  sum: TRIT_TWO};
         4'd6: d = '{carry: TRIT_TWO,  sum: TRIT_ZERO};
         4'd7: d = '{carry: TRIT_TWO,  sum: TRIT_ONE};
         4'd8: d = '{carry: TRIT_TWO,  sum: TRIT_TWO};
         default: d = '{carry: TRIT_TWO, sum: TRIT_ZERO};
      endcase
      return d;
   endfunction

   function automatic trit_type map_apply(trit_map_type m, trit_type c);
      trit_type r;
      unique case (c)
         TRIT_ONE: r = m[1];
         TRIT_TWO: r = m[2];
         default:  r = m[0];
      endcase
      return r;
   endfunction

   // first applied, then second
   function automatic trit_map_type map_then(trit_map_type first, trit_map_type second);
      trit_map_type h;
      h[0] = map_apply(second, first[0]);
      h[1] = map_apply(second, first[1]);
      h[2] = map_apply(second, first[2]);
      return h;
   endfunction

endpackage

// ===== sv/tgu_lane.sv =====
module tgu_lane (
   input  tgu_pkg::trit_type     a,
   input  tgu_pkg::trit_type     b,
   input  logic                  enable,
   output tgu_pkg::lane_map_type lane_map
);

   tgu_pkg::digit_type dig [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dig[c] = tgu_pkg::add_digits(4'(a) + 4'(b) + 4'(c));
      end
      for (int c = 0; c < 3; c++) begin
         if (enable) begin
            lane_map.sum[c]   = dig[c].sum;
            lane_map.carry[c] = dig[c].carry;
         end else begin
            // disabled lane passes the carry and contributes no sum
            lane_map.sum[c]   = tgu_pkg::TRIT_ZERO;
            lane_map.carry[c] = tgu_pkg::trit_type'(c);
         end
      end
   end

endmodule

// ===== sv/tgu_merge.sv =====
module tgu_merge (
   input  tgu_pkg::lane_map_type lanes [tgu_pkg::WORD_TRITS],
   output tgu_pkg::trit_type     sum_trits [tgu_pkg::WORD_TRITS],
   output tgu_pkg::trit_type     carry_out
);

   tgu_pkg::trit_map_type prefix [tgu_pkg::LEVELS+1][tgu_pkg::WORD_TRITS];

   // parallel prefix of the carry maps
   for (genvar i = 0; i < tgu_pkg::WORD_TRITS; i++) begin : g_base
      assign prefix[0][i] = lanes[i].carry;
   end

   for (genvar l = 0; l < tgu_pkg::LEVELS; l++) begin : g_level
      localparam int Span = 1 << l;
      for (genvar i = 0; i < tgu_pkg::WORD_TRITS; i++) begin : g_node
         if (i >= Span) begin : g_comb
            assign prefix[l+1][i] = tgu_pkg::map_then(prefix[l][i-Span], prefix[l][i]);
         end else begin : g_pass
            assign prefix[l+1][i] = prefix[l][i];
         end
      end
   end

   for (genvar i = 0; i < tgu_pkg::WORD_TRITS; i++) begin : g_sum
      if (i == 0) begin : g_first
         assign sum_trits[i] = tgu_pkg::map_apply(lanes[i].sum, tgu_pkg::TRIT_ZERO);
      end else begin : g_rest
         assign sum_trits[i] = tgu_pkg::map_apply(lanes[i].sum,
            tgu_pkg::map_apply(prefix[tgu_pkg::LEVELS][i-1], tgu_pkg::TRIT_ZERO));
      end
   end

   assign carry_out = tgu_pkg::map_apply(prefix[tgu_pkg::LEVELS][tgu_pkg::WORD_TRITS-1],
                                         tgu_pkg::TRIT_ZERO);

endmodule

// ===== sv/tgu_gate.sv =====
module tgu_gate (
   input  logic [tgu_pkg::OPCODE_W-1:0] opcode,
   input  tgu_pkg::trit_type            a,
   input  tgu_pkg::trit_type            b,
   input  tgu_pkg::trit_type            cin,
   input  logic [tgu_pkg::CNT_W-1:0]    count,
   input  logic [tgu_pkg::COST_W-1:0]   cost_not,
   input  logic [tgu_pkg::COST_W-1:0]   cost_nand,
   input  logic [tgu_pkg::COST_W-1:0]   cost_full_add,
   output tgu_pkg::gate_info_type       info
);

   tgu_pkg::opcode_type op;
   tgu_pkg::digit_type  half_dig;
   tgu_pkg::digit_type  full_dig;
   logic [tgu_pkg::ENERGY_W-1:0] e_not;
   logic [tgu_pkg::ENERGY_W-1:0] e_nand;
   logic [tgu_pkg::ENERGY_W-1:0] e_fa;

   assign op       = tgu_pkg::opcode_type'(opcode);
   assign half_dig = tgu_pkg::add_digits(4'(a) + 4'(b));
   assign full_dig = tgu_pkg::add_digits(4'(a) + 4'(b) + 4'(cin));
   assign e_not    = tgu_pkg::ENERGY_W'(cost_not);
   assign e_nand   = tgu_pkg::ENERGY_W'(cost_nand);
   assign e_fa     = tgu_pkg::ENERGY_W'(cost_full_add);

   always_comb begin
      info = '0;
      unique case (op)
         tgu_pkg::OP_NOT: begin
            info.res         = tgu_pkg::trit_inv(a);
            info.gates       = tgu_pkg::ACT_W'(1);
            info.transitions = tgu_pkg::ACT_W'(1);
            info.energy      = e_not;
            info.delay_set   = 1'b1;
            info.delay       = tgu_pkg::DELAY_INV;
         end
         tgu_pkg::OP_NAND: begin
            info.res         = tgu_pkg::trit_nand(a, b);
            info.gates       = tgu_pkg::ACT_W'(1);
            info.transitions = tgu_pkg::ACT_W'(1);
            info.energy      = e_nand;
            info.delay_set   = 1'b1;
            info.delay       = tgu_pkg::DELAY_NAND;
         end
         tgu_pkg::OP_NOR: begin
            info.res         = tgu_pkg::trit_inv(tgu_pkg::trit_max(a, b));
            info.gates       = tgu_pkg::ACT_W'(2);
            info.transitions = tgu_pkg::ACT_W'(2);
            info.energy      = e_nand + e_not;
            info.delay_set   = 1'b1;
            info.delay       = tgu_pkg::DELAY_INV;
         end
         tgu_pkg::OP_AND: begin
            info.res         = tgu_pkg::trit_inv(tgu_pkg::trit_nand(a, b));
            info.gates       = tgu_pkg::ACT_W'(2);
            info.transitions = tgu_pkg::ACT_W'(2);
            info.energy      = e_nand + e_not;
            info.delay_set   = 1'b1;
            info.delay       = tgu_pkg::DELAY_INV;
         end
         tgu_pkg::OP_OR: begin
            info.res         = tgu_pkg::trit_inv(tgu_pkg::trit_inv(tgu_pkg::trit_max(a, b)));
            info.gates       = tgu_pkg::ACT_W'(3);
            info.transitions = tgu_pkg::ACT_W'(3);
            info.energy      = e_nand + (e_not << 1);
            info.delay_set   = 1'b1;
            info.delay       = tgu_pkg::DELAY_INV;
         end
         tgu_pkg::OP_MIN: begin
            info.res   = tgu_pkg::trit_min(a, b);
            info.gates = tgu_pkg::ACT_W'(1);
         end
         tgu_pkg::OP_MAX: begin
            info.res   = tgu_pkg::trit_max(a, b);
            info.gates = tgu_pkg::ACT_W'(1);
         end
         tgu_pkg::OP_HALF_ADD: begin
            info.res         = half_dig.sum;
            info.carry       = half_dig.carry;
            info.gates       = tgu_pkg::ACT_W'(1);
            info.transitions = tgu_pkg::ACT_W'(1);
            info.energy      = (e_nand << 1) + e_nand;
         end
         tgu_pkg::OP_FULL_ADD: begin
            info.res         = full_dig.sum;
            info.carry       = full_dig.carry;
            info.gates       = tgu_pkg::ACT_W'(1);
            info.transitions = tgu_pkg::ACT_W'(1);
            info.energy      = e_fa;
            info.delay_set   = 1'b1;
            info.delay       = tgu_pkg::DELAY_ADD;
         end
         tgu_pkg::OP_WORD_ADD: begin
            info.word_add    = 1'b1;
            info.gates       = tgu_pkg::ACT_W'(count);
            info.transitions = tgu_pkg::ACT_W'(count);
            info.energy      = tgu_pkg::ENERGY_W'(count) * e_fa;
            info.delay_set   = (count != '0);
            info.delay       = tgu_pkg::DELAY_ADD;
         end
         default: begin
            info = '0;
         end
      endcase
   end

endmodule

// ===== sv/ternary_gate_unit_with_activity.sv =====
// a beat accepted on req is registered in stage 1 and then in the rsp registers
// throughput: one beat per cycle while rsp is not stalled; lane maps are registered, then the carry
// prefix merge and the activity counters update in the second stage
// a stalled rsp holds both stages; req_ready drops only while both are full
// reset clears counters, last delay, cost registers and both valid stages
module ternary_gate_unit_with_activity (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tgu_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [tgu_pkg::WORD_W-1:0]      req_operand_a,
   input  logic [tgu_pkg::WORD_W-1:0]      req_operand_b,
   input  logic [tgu_pkg::TRIT_W-1:0]      req_carry_in,
   input  logic [tgu_pkg::COUNT_IN_W-1:0]  req_trit_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tgu_pkg::WORD_W-1:0]      rsp_result_word,
   output logic [tgu_pkg::TRIT_W-1:0]      rsp_carry_out,
   output logic [31:0]                     rsp_gates_total,
   output logic [31:0]                     rsp_transitions_total,
   output logic [31:0]                     rsp_energy_total,
   output logic [tgu_pkg::DELAY_W-1:0]     rsp_delay_ps,
   input  logic                            csr_wen,
   input  logic [tgu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgu_pkg::COST_W-1:0]      csr_wdata
);

   logic [tgu_pkg::COST_W-1:0] cost_not_ff, cost_not_in;
   logic [tgu_pkg::COST_W-1:0] cost_nand_ff, cost_nand_in;
   logic [tgu_pkg::COST_W-1:0] cost_fa_ff, cost_fa_in;

   logic                   s1_valid_ff, s1_valid_in;
   tgu_pkg::gate_info_type s1_info_ff, s1_info_in;
   tgu_pkg::lane_map_type  s1_lane_ff [tgu_pkg::WORD_TRITS];
   tgu_pkg::lane_map_type  s1_lane_in [tgu_pkg::WORD_TRITS];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tgu_pkg::WORD_W-1:0]    rsp_result_word_ff, rsp_result_word_in;
   tgu_pkg::trit_type             rsp_carry_out_ff, rsp_carry_out_in;
   logic [31:0]                   gate_count_ff, gate_count_in;
   logic [31:0]                   trans_count_ff, trans_count_in;
   logic [31:0]                   energy_sum_ff, energy_sum_in;
   logic [tgu_pkg::DELAY_W-1:0]   last_delay_ff, last_delay_in;

   logic                           advance;
   logic                           take;
   logic                           word_op;
   logic [tgu_pkg::CNT_W-1:0]      count_clamped;
   tgu_pkg::trit_type              lane_a [tgu_pkg::WORD_TRITS];
   tgu_pkg::trit_type              lane_b [tgu_pkg::WORD_TRITS];
   tgu_pkg::trit_type              merged_sum [tgu_pkg::WORD_TRITS];
   tgu_pkg::trit_type              merged_carry;
   tgu_pkg::trit_type [tgu_pkg::OPERAND_TRITS-1:0] word_trits;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign take      = req_valid && req_ready;

   // config registers
   always_comb begin
      cost_not_in  = cost_not_ff;
      cost_nand_in = cost_nand_ff;
      cost_fa_in   = cost_fa_ff;
      if (csr_wen) begin
         unique case (csr_index)
            tgu_pkg::CSR_COST_NOT:      cost_not_in  = csr_wdata;
            tgu_pkg::CSR_COST_NAND:     cost_nand_in = csr_wdata;
            tgu_pkg::CSR_COST_FULL_ADD: cost_fa_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_not_ff  <= '0;
         cost_nand_ff <= '0;
         cost_fa_ff   <= '0;
      end else begin
         cost_not_ff  <= cost_not_in;
         cost_nand_ff <= cost_nand_in;
         cost_fa_ff   <= cost_fa_in;
      end
   end

   // stage 1: lanes and single-trit gate
   assign count_clamped = (32'(req_trit_count) > 32'(tgu_pkg::WORD_TRITS))
                        ? tgu_pkg::CNT_W'(tgu_pkg::WORD_TRITS)
                        : tgu_pkg::CNT_W'(req_trit_count);
   assign word_op = (req_opcode == tgu_pkg::OP_WORD_ADD);

   for (genvar i = 0; i < tgu_pkg::WORD_TRITS; i++) begin : g_lane
      if (i < tgu_pkg::OPERAND_TRITS) begin : g_read
         assign lane_a[i] = req_operand_a[tgu_pkg::TRIT_W*i +: tgu_pkg::TRIT_W];
         assign lane_b[i] = req_operand_b[tgu_pkg::TRIT_W*i +: tgu_pkg::TRIT_W];
      end else begin : g_zero
         assign lane_a[i] = tgu_pkg::TRIT_ZERO;
         assign lane_b[i] = tgu_pkg::TRIT_ZERO;
      end
      tgu_lane u_lane (
         .a        (lane_a[i]),
         .b        (lane_b[i]),
         .enable   (word_op && (tgu_pkg::CNT_W'(i) < count_clamped)),
         .lane_map (s1_lane_in[i])
      );
   end

   tgu_gate u_gate (
      .opcode        (req_opcode),
      .a             (req_operand_a[tgu_pkg::TRIT_W-1:0]),
      .b             (req_operand_b[tgu_pkg::TRIT_W-1:0]),
      .cin           (req_carry_in),
      .count         (count_clamped),
      .cost_not      (cost_not_ff),
      .cost_nand     (cost_nand_ff),
      .cost_full_add (cost_fa_ff),
      .info          (s1_info_in)
   );

   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_info_ff <= s1_info_in;
         s1_lane_ff <= s1_lane_in;
      end
   end

   // stage 2: carry merge and counters
   tgu_merge u_merge (
      .lanes     (s1_lane_ff),
      .sum_trits (merged_sum),
      .carry_out (merged_carry)
   );

   for (genvar i = 0; i < tgu_pkg::OPERAND_TRITS; i++) begin : g_word
      if (i < tgu_pkg::WORD_TRITS) begin : g_used
         assign word_trits[i] = merged_sum[i];
      end else begin : g_unused
         assign word_trits[i] = tgu_pkg::TRIT_ZERO;
      end
   end

   always_comb begin
      rsp_valid_in       = advance ? s1_valid_ff : rsp_valid_ff;
      rsp_result_word_in = s1_info_ff.word_add ? tgu_pkg::WORD_W'(word_trits)
                                               : tgu_pkg::WORD_W'(s1_info_ff.res);
      rsp_carry_out_in   = s1_info_ff.word_add ? merged_carry : s1_info_ff.carry;
      gate_count_in      = gate_count_ff + 32'(s1_info_ff.gates);
      trans_count_in     = trans_count_ff + 32'(s1_info_ff.transitions);
      energy_sum_in      = energy_sum_ff + 32'(s1_info_ff.energy);
      last_delay_in      = s1_info_ff.delay_set ? s1_info_ff.delay : last_delay_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         gate_count_ff  <= '0;
         trans_count_ff <= '0;
         energy_sum_ff  <= '0;
         last_delay_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance && s1_valid_ff) begin
            gate_count_ff  <= gate_count_in;
            trans_count_ff <= trans_count_in;
            energy_sum_ff  <= energy_sum_in;
            last_delay_ff  <= last_delay_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_result_word_ff <= rsp_result_word_in;
         rsp_carry_out_ff   <= rsp_carry_out_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_word       = rsp_result_word_ff;
   assign rsp_carry_out         = rsp_carry_out_ff;
   assign rsp_gates_total       = gate_count_ff;
   assign rsp_transitions_total = trans_count_ff;
   assign rsp_energy_total      = energy_sum_ff;
   assign rsp_delay_ps          = last_delay_ff;

   a_carry_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_carry_out_ff != 2'd3)
      else $error("carry out holds invalid trit code");

   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff) |=> $stable(gate_count_ff) && $stable(energy_sum_ff))
      else $error("counters moved without a beat leaving stage 1");

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_info_ff))
      else $error("stage 1 beat overwritten while output stalled");

   a_delay_code : assert property (@(posedge clock) disable iff (reset)
      last_delay_ff == '0 || last_delay_ff == tgu_pkg::DELAY_INV ||
      last_delay_ff == tgu_pkg::DELAY_NAND || last_delay_ff == tgu_pkg::DELAY_ADD)
      else $error("last delay holds an unknown value");

endmodule
